// File: rtl/core/lgs_pkg.sv
//------------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step block.
//------------------------------------------------------------------------------
package lgs_pkg;

	localparam int GRID_SIDE = 128;
	localparam int CW = $clog2(GRID_SIDE);
	localparam int AW = 2 * CW;

	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_SET    = 3'd1,
		MODE_TOGGLE = 3'd2,
		MODE_TICK   = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_RD,
		ST_RMW,
		ST_GPRE,
		ST_GRUN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic acc_rd;
		logic acc_wr;
		logic gen_start;
		logic gen_step;
		logic cap;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic gen_done;
	} sts_t;

endpackage

// File: rtl/core/lgs_ctrl.sv
//------------------------------------------------------------------------------
// lgs_ctrl
// Sequencer: accepts a transaction, runs the datapath, holds the result.
//------------------------------------------------------------------------------
module lgs_ctrl import lgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [2:0] mode,
	input  logic       on_grid,
	input  logic       run_en,
	input  logic       out_fire,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       out_valid
);

	state_t state_q, state_nxt;

	// after reset the grid is swept clear before the first transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: if (sts.clr_done) state_nxt = ST_IDLE;
			ST_IDLE: begin
				if (in_fire) begin
					unique case (mode) inside
						MODE_CLEAR: state_nxt = ST_CLR;
						MODE_SET, MODE_TOGGLE, MODE_READ:
							state_nxt = on_grid ? ST_RD : ST_OUT;
						MODE_TICK: state_nxt = run_en ? ST_GPRE : ST_OUT;
						default: state_nxt = ST_OUT;
					endcase
				end
			end
			ST_CLR:  if (sts.clr_done) state_nxt = ST_OUT;
			ST_RD:   state_nxt = ST_RMW;
			ST_RMW:  state_nxt = ST_OUT;
			ST_GPRE: state_nxt = ST_GRUN;
			ST_GRUN: if (sts.gen_done) state_nxt = ST_OUT;
			ST_OUT:  if (out_fire) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cap = in_fire;
				cmd.clr_start = in_fire && (mode == MODE_CLEAR);
				cmd.gen_start = in_fire && (mode == MODE_TICK);
			end
			ST_INIT, ST_CLR: cmd.clr_step = 1'b1;
			ST_RD:   cmd.acc_rd = 1'b1;
			ST_RMW:  cmd.acc_wr = 1'b1;
			ST_GPRE, ST_GRUN: cmd.gen_step = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

endmodule

// File: rtl/core/lgs_dp.sv
//------------------------------------------------------------------------------
// lgs_dp
// Grid memory, cell access and the row-streaming generation engine.
//------------------------------------------------------------------------------
module lgs_dp import lgs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [2:0]    mode,
	input  logic [CW-1:0] row,
	input  logic [CW-1:0] col,
	input  logic          value,
	input  logic          run_en,
	output sts_t          sts,
	output logic          cell_state,
	output logic          advanced
);

	// grid stored one row per word
	logic [GRID_SIDE-1:0] mem [GRID_SIDE];
	logic [GRID_SIDE-1:0] rdata_q;
	logic [GRID_SIDE-1:0] above_q, here_q;
	logic [CW-1:0]        row_q, col_q, ptr_q;
	logic [CW:0]          gcnt_q;
	logic [2:0]           mode_q;
	logic                 val_q, cell_q, adv_q;

	logic [CW-1:0]        raddr;
	logic [GRID_SIDE-1:0] wdata, below, next_row;
	logic [CW-1:0]        waddr;
	logic                 we;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			row_q  <= row;
			col_q  <= col;
			val_q  <= value;
		end
	end

	// gen: gcnt counts 0..GRID_SIDE; in step k (k>=1) row k-1 is written
	always_comb begin
		raddr = row_q;
		if (cmd.gen_step) raddr = (gcnt_q[CW-1:0] == CW'(GRID_SIDE - 1)) ? '0
			: gcnt_q[CW-1:0] + CW'(1);
		if (cmd.gen_start) raddr = '0;
	end

	always_ff @(posedge clk) rdata_q <= mem[raddr];

	// rdata_q holds row gcnt during gen_step (read ahead)
	assign below = (gcnt_q == (CW+1)'(GRID_SIDE)) ? '0 : rdata_q;

	always_comb begin
		for (int c = 0; c < GRID_SIDE; c++) begin
			logic [3:0] n;
			n = 4'd0;
			for (int d = -1; d <= 1; d++) begin
				if (c + d >= 0 && c + d < GRID_SIDE) begin
					n = n + 4'(above_q[c+d]) + 4'(below[c+d]);
					if (d != 0) n = n + 4'(here_q[c+d]);
				end
			end
			next_row[c] = (n == 4'd3) || (here_q[c] && n == 4'd2);
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = row_q;
		wdata = rdata_q;
		if (cmd.clr_step) begin
			we = 1'b1; waddr = ptr_q; wdata = '0;
		end else if (cmd.acc_wr) begin
			we = (mode_q == MODE_SET) || (mode_q == MODE_TOGGLE);
			if (mode_q == MODE_SET) wdata[col_q] = val_q;
			else if (mode_q == MODE_TOGGLE) wdata[col_q] = ~rdata_q[col_q];
		end else if (cmd.gen_step && gcnt_q != '0) begin
			we = 1'b1; waddr = gcnt_q[CW-1:0] - CW'(1); wdata = next_row;
		end
	end

	always_ff @(posedge clk) if (we) mem[waddr] <= wdata;

	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			above_q <= '0;
			here_q  <= '0;
		end else if (cmd.gen_step) begin
			above_q <= here_q;
			here_q  <= below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0; gcnt_q <= '0; cell_q <= 1'b0; adv_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				gcnt_q <= '0; cell_q <= 1'b0;
				adv_q <= (mode == MODE_TICK) && run_en;
			end
			if (cmd.clr_start) ptr_q <= '0;
			if (cmd.clr_step) ptr_q <= ptr_q + CW'(1);
			if (cmd.gen_step) gcnt_q <= gcnt_q + (CW+1)'(1);
			if (cmd.acc_wr) cell_q <= wdata[col_q];
		end
	end

	assign sts.clr_done = cmd.clr_step && (ptr_q == CW'(GRID_SIDE - 1));
	assign sts.gen_done = cmd.gen_step && (gcnt_q == (CW+1)'(GRID_SIDE));
	assign cell_state = cell_q;
	assign advanced = adv_q;

endmodule

// File: rtl/core/life_grid_generation_step_top.sv
//------------------------------------------------------------------------------
// life_grid_generation_step_top
// B3/S23 cellular automaton on a 128x128 grid with cell access commands.
//------------------------------------------------------------------------------
// Steps: set/toggle/read read the row and write it back (set/toggle only),
// then output; clear, tick sweep all rows; paused tick, unused modes output.
// Throughput: one transaction at a time; a tick streams one 128-cell row per
// cycle through a three-row window, so the grid's single row port sets it.
// Reset: asynchronous, active low; controller and run_enable cleared, then a
// sweep clears the grid row by row while s_axis_tready stays low.
module life_grid_generation_step_top import lgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        run_enable_we,
	input  logic        run_enable_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // mode[2:0], row[9:3], col[16:10], value[17]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // cell_state[0], advanced[1]
);

	cmd_t cmd;
	sts_t sts;
	logic busy, run_q, in_fire, out_fire, on_grid, cs, adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) run_q <= 1'b0;
		else if (run_enable_we) run_q <= run_enable_wdata;
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign on_grid = 1'b1; // 7-bit row/col always inside a 128 grid

	lgs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .mode(s_axis_tdata[2:0]),
		.on_grid(on_grid), .run_en(run_q), .out_fire(out_fire), .sts(sts),
		.cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	lgs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .mode(s_axis_tdata[2:0]),
		.row(s_axis_tdata[9:3]), .col(s_axis_tdata[16:10]), .value(s_axis_tdata[17]),
		.run_en(run_q), .sts(sts), .cell_state(cs), .advanced(adv)
	);

	assign m_axis_tdata = {6'd0, adv, cs};

endmodule

// File: test/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Checks the life grid block: cell commands, clears and generation ticks.
// A directed table runs first, then random command streams. The random
// streams build small patterns and let them evolve, under three back-pressure
// profiles. Results are compared with a local B3/S23 model or typed-in values.
//------------------------------------------------------------------------------
module tb_top import lgs_pkg::*; ();

	localparam logic [2:0] MODE_RSVD_A = 3'd5;
	localparam logic [2:0] MODE_RSVD_B = 3'd6;
	localparam logic [2:0] MODE_RSVD_C = 3'd7;
	localparam int         RAND_ITEMS  = 26;     // per phase, three phases
	localparam int         STALL_LIMIT = 20000;  // cycles without a transaction
	localparam int         SETTLE      = 140;    // a little over the tick latency

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        run_enable_we = 1'b0;
	logic        run_enable_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	typedef struct {
		bit       cs;
		bit       adv;
	} cell_result_t;

	typedef struct {
		bit       is_cfg;
		bit       cfg_val;
		bit [2:0] mode;
		bit [6:0] row;
		bit [6:0] col;
		bit       value;
		bit       fixed;    // expected result typed in below
		bit       e_cs;
		bit       e_adv;
	} cmd_row_t;

	bit           grid_model [GRID_SIDE][GRID_SIDE];
	bit           run_en_model;
	cell_result_t pending_results[$];
	cmd_row_t     cmd_table[$];
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	int           mismatches = 0;
	int           idle_cycles = 0;
	bit           s_fire;

	life_grid_generation_step_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.run_enable_we    (run_enable_we),
		.run_enable_wdata (run_enable_wdata),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one B3/S23 generation, edges count as dead
	function automatic void step_generation();
		bit old_grid [GRID_SIDE][GRID_SIDE];
		int live;
		old_grid = grid_model;
		for (int r = 0; r < GRID_SIDE; r++) begin
			for (int c = 0; c < GRID_SIDE; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_SIDE &&
								c + dc >= 0 && c + dc < GRID_SIDE) begin
							live += old_grid[r + dr][c + dc];
						end
					end
				end
				grid_model[r][c] = old_grid[r][c] ? (live == 2 || live == 3) : (live == 3);
			end
		end
	endfunction

	// applies one command to the grid model and returns what the block reports
	function automatic cell_result_t apply_command(bit [2:0] mode, bit [6:0] row,
			bit [6:0] col, bit value);
		cell_result_t res;
		res = '{cs: 1'b0, adv: 1'b0};
		case (mode)
			MODE_CLEAR: begin
				foreach (grid_model[r, c]) grid_model[r][c] = 1'b0;
			end
			MODE_SET: begin
				grid_model[row][col] = value;
				res.cs = value;
			end
			MODE_TOGGLE: begin
				grid_model[row][col] = ~grid_model[row][col];
				res.cs = grid_model[row][col];
			end
			MODE_TICK: begin
				if (run_en_model) begin
					step_generation();
					res.adv = 1'b1;
				end
			end
			MODE_READ: res.cs = grid_model[row][col];
			default: ;
		endcase
		return res;
	endfunction

	function automatic void add_row(cmd_row_t r);
		cmd_table = {cmd_table, r};
	endfunction

	// drive one command and wait for its transaction
	task automatic send_command(bit [2:0] mode, bit [6:0] row, bit [6:0] col, bit value,
			bit fixed, bit e_cs, bit e_adv);
		cell_result_t res;
		bit           ready;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, value, col, row, mode};
		// tready is sampled mid-cycle, ahead of the edge that takes it
		do begin
			@(negedge clk);
			ready = s_axis_tready;
			@(posedge clk);
		end while (!ready);
		res = apply_command(mode, row, col, value);
		if (fixed) res = '{cs: e_cs, adv: e_adv};
		pending_results = {pending_results, res};
	endtask

	// only between commands, with nothing in flight
	task automatic write_run_enable(bit val);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		run_enable_we    <= 1'b1;
		run_enable_wdata <= val;
		@(posedge clk);
		run_enable_we    <= 1'b0;
		run_en_model = val;
	endtask

	// random commands, mostly clustered in an 8x8 window so patterns interact
	task automatic random_phase(int count);
		bit [6:0] base_r, base_c, row, col;
		bit [2:0] mode;
		int       pick;
		base_r = 7'd60;
		base_c = 7'd60;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(2))
					0: begin base_r = 7'd0;   base_c = 7'd120; end
					1: begin base_r = 7'd120; base_c = 7'd0;   end
					default: begin
						base_r = 7'($urandom_range(120));
						base_c = 7'($urandom_range(120));
					end
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 32)      mode = MODE_SET;
			else if (pick < 47) mode = MODE_TOGGLE;
			else if (pick < 72) mode = MODE_READ;
			else if (pick < 88) mode = MODE_TICK;
			else if (pick < 92) mode = MODE_CLEAR;
			else case ($urandom_range(2))
				0: mode = MODE_RSVD_A;
				1: mode = MODE_RSVD_B;
				default: mode = MODE_RSVD_C;
			endcase
			if ($urandom_range(4) == 0) begin
				row = 7'($urandom_range(127));
				col = 7'($urandom_range(127));
			end else begin
				row = base_r + 7'($urandom_range(7));
				col = base_c + 7'($urandom_range(7));
			end
			send_command(mode, row, col, $urandom_range(3) != 0, 1'b0, 1'b0, 1'b0);
		end
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result checker: looks mid-cycle at the transaction the next edge takes
	always @(negedge clk) begin
		cell_result_t exp_res;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %h", m_axis_tdata);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata[0] !== exp_res.cs || m_axis_tdata[1] !== exp_res.adv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: cell_state exp %0b got %b, advanced exp %0b got %b",
							exp_res.cs, m_axis_tdata[0], exp_res.adv, m_axis_tdata[1]);
				end
			end
		end
	end

	// watchdog: counts cycles with no transaction on either side
	always @(negedge clk) begin
		s_fire = s_axis_tvalid && s_axis_tready;
		if (s_fire || (m_axis_tvalid && m_axis_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		foreach (grid_model[r, c]) grid_model[r][c] = 1'b0;
		run_en_model = 1'b0;

		// directed table; first read checks that reset left the grid dead
		add_row('{0, 0, MODE_READ,   64,  64,  0, 1, 0, 0});
		add_row('{0, 0, MODE_READ,   0,   0,   0, 1, 0, 0});
		add_row('{0, 0, MODE_SET,    0,   0,   1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    127, 127, 1, 1, 1, 0});
		add_row('{0, 0, MODE_TOGGLE, 127, 127, 0, 1, 0, 0});
		add_row('{0, 0, MODE_TOGGLE, 0,   127, 1, 1, 1, 0});
		add_row('{0, 0, MODE_READ,   0,   127, 0, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    127, 0,   0, 1, 0, 0});
		add_row('{0, 0, MODE_TICK,   0,   0,   0, 1, 0, 0}); // paused
		add_row('{0, 0, MODE_READ,   0,   0,   0, 1, 1, 0});
		add_row('{0, 0, MODE_RSVD_A, 85,  42,  1, 1, 0, 0});
		add_row('{0, 0, MODE_RSVD_B, 42,  85,  0, 1, 0, 0});
		add_row('{0, 0, MODE_RSVD_C, 127, 127, 1, 1, 0, 0});
		add_row('{1, 1, 0,           0,   0,   0, 0, 0, 0});
		add_row('{0, 0, MODE_CLEAR,  0,   0,   0, 1, 0, 0});
		// blinker in the middle, corner L that grows into a block
		add_row('{0, 0, MODE_SET,    64,  63,  1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    64,  64,  1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    64,  65,  1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    0,   0,   1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    0,   1,   1, 1, 1, 0});
		add_row('{0, 0, MODE_SET,    1,   0,   1, 1, 1, 0});
		add_row('{0, 0, MODE_TICK,   0,   0,   0, 1, 0, 1});
		add_row('{0, 0, MODE_READ,   63,  64,  0, 0, 0, 0});
		add_row('{0, 0, MODE_READ,   64,  63,  0, 0, 0, 0});
		add_row('{0, 0, MODE_READ,   1,   1,   0, 0, 0, 0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 35;
		rx_idle_pct = 88;
		foreach (cmd_table[i]) begin
			if (cmd_table[i].is_cfg) write_run_enable(cmd_table[i].cfg_val);
			else send_command(cmd_table[i].mode, cmd_table[i].row, cmd_table[i].col,
				cmd_table[i].value, cmd_table[i].fixed, cmd_table[i].e_cs, cmd_table[i].e_adv);
		end
		random_phase(RAND_ITEMS);

		// paused phase, roles swapped
		write_run_enable(1'b0);
		tx_idle_pct = 88;
		rx_idle_pct = 35;
		random_phase(RAND_ITEMS);

		// full speed
		write_run_enable(1'b1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(RAND_ITEMS);

		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
